[rtl/core/dcra_pkg.sv]
// Shared types and constants for the DMA channel register file and arbiter.
// No dependencies; imported by every module of the block.
package dcra_pkg;

  localparam int NUM_CHANNELS_DEF = 7;
  localparam int MAX_CHANNELS     = 7;   // channels reachable by offset, flags and masks
  localparam int OTC_INDEX        = 6;

  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;

  localparam logic [31:0] DICR_KEEP  = 32'h00FF_803F;
  localparam logic [31:0] OTC_KEEP   = 32'h5100_0000;
  localparam logic [31:0] DIR_BIT    = 32'h0000_0002;
  localparam logic [31:0] PRIO_RESET = 32'h0765_4321;

  // Word offsets (byte offset >> 2) of the global registers
  localparam logic [4:0] DPCR_WORD = 5'h1C;
  localparam logic [4:0] DICR_WORD = 5'h1D;
  // Channel region ends where the channel field reads seven
  localparam logic [2:0] GLOBAL_ROW = 3'd7;

  // Register select within a channel row
  localparam logic [1:0] SEL_ADDR  = 2'd0;
  localparam logic [1:0] SEL_BLOCK = 2'd1;
  localparam logic [1:0] SEL_CTRL  = 2'd2;

  typedef enum logic [1:0] {
    CMD_READ     = 2'd0,
    CMD_WRITE    = 2'd1,
    CMD_COMPLETE = 2'd2,
    CMD_ARB      = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [6:0]  offset;
    logic [31:0] wdata;
    logic [2:0]  channel;
  } req_t;

  // Control bits of one channel that arbitration looks at
  typedef struct packed {
    logic       en;
    logic       trig;
    logic [1:0] sync;
  } chan_stat_t;

endpackage

[rtl/core/dcra_regs.sv]
// Channel, priority and interrupt registers with bus read/write decode.
// Depends on dcra_pkg.
module dcra_regs #(
  parameter int NUM_CHANNELS = dcra_pkg::NUM_CHANNELS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    fire,
  input  dcra_pkg::req_t          req,
  output logic [31:0]             rdata,
  output logic                    rise,
  output dcra_pkg::chan_stat_t    stat [(NUM_CHANNELS > dcra_pkg::MAX_CHANNELS ?
                                         dcra_pkg::MAX_CHANNELS : NUM_CHANNELS)],
  output logic [31:0]             dpcr
);
  import dcra_pkg::*;

  localparam int NCH  = (NUM_CHANNELS > MAX_CHANNELS) ? MAX_CHANNELS : NUM_CHANNELS;
  localparam int CH_W = (NCH > 1) ? $clog2(NCH) : 1;

  logic [23:0] addr_r [NCH];
  logic [31:0] block_r [NCH];
  logic [31:0] ctrl_r [NCH];
  logic [31:0] dpcr_r;
  logic [30:0] dicr_r;
  logic [30:0] dicr_nxt;

  logic [1:0]     lane;
  logic [31:0]    word;
  logic [2:0]     row;
  logic [1:0]     sel;
  logic           row_ok;
  logic [CH_W-1:0] chi;
  logic [31:0]    reg_val;
  logic           comp_ok;
  logic [6:0]     flags_kept;
  logic [6:0]     ch_onehot;

  function automatic logic irq_line(input logic [30:0] d);
    irq_line = d[15] | (d[23] & (|(d[22:16] & d[30:24])));
  endfunction

  assign lane   = req.offset[1:0];
  assign word   = req.wdata << {lane, 3'b000};
  assign row    = req.offset[6:4];
  assign sel    = req.offset[3:2];
  assign row_ok = (row != GLOBAL_ROW) && (row < 3'(NCH));
  assign chi    = row[CH_W-1:0];

  // Register read mux, whole word before the lane shift
  always_comb begin
    reg_val = '0;
    if (row_ok) begin
      case (sel)
        SEL_ADDR:  reg_val = {8'h00, addr_r[chi]};
        SEL_BLOCK: reg_val = block_r[chi];
        SEL_CTRL:  reg_val = ctrl_r[chi];
        default:   reg_val = '0;
      endcase
    end else if (req.offset[6:2] == DPCR_WORD) begin
      reg_val = dpcr_r;
    end else if (req.offset[6:2] == DICR_WORD) begin
      reg_val = {irq_line(dicr_r), dicr_r};
    end
  end

  assign rdata = reg_val >> {lane, 3'b000};

  // Interrupt register next value: acknowledge on write, flag on complete
  assign flags_kept = dicr_r[30:24] & ~word[30:24];
  assign ch_onehot  = 7'd1 << req.channel;
  assign comp_ok    = (req.channel < 3'(NCH)) && (|(dicr_r[22:16] & ch_onehot));

  always_comb begin
    dicr_nxt = dicr_r;
    case (req.cmd)
      CMD_WRITE: begin
        if (req.offset[6:2] == DICR_WORD) begin
          dicr_nxt = {flags_kept, word[23:0] & DICR_KEEP[23:0]};
        end
      end
      CMD_COMPLETE: begin
        if (comp_ok) begin
          dicr_nxt[30:24] = dicr_r[30:24] | ch_onehot;
        end
      end
      default: dicr_nxt = dicr_r;
    endcase
  end

  assign rise = !irq_line(dicr_r) && irq_line(dicr_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCH; i++) begin
        addr_r[i]  <= '0;
        block_r[i] <= '0;
        ctrl_r[i]  <= (i == OTC_INDEX) ? DIR_BIT : '0;
      end
      dpcr_r <= PRIO_RESET;
      dicr_r <= '0;
    end else if (fire) begin
      dicr_r <= dicr_nxt;
      if (req.cmd == CMD_WRITE) begin
        if (row_ok) begin
          case (sel)
            SEL_ADDR:  addr_r[chi]  <= word[23:0];
            SEL_BLOCK: block_r[chi] <= word;
            SEL_CTRL:  ctrl_r[chi]  <= (32'(chi) == OTC_INDEX) ?
                                       ((word & OTC_KEEP) | DIR_BIT) : word;
            default: ;
          endcase
        end else if (req.offset[6:2] == DPCR_WORD) begin
          dpcr_r <= word;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      stat[i].en   = ctrl_r[i][24];
      stat[i].trig = ctrl_r[i][28];
      stat[i].sync = ctrl_r[i][10:9];
    end
  end

  assign dpcr = dpcr_r;

endmodule

[rtl/core/dcra_arb.sv]
// Priority arbiter over the ready, asking channels.
// Depends on dcra_pkg.
module dcra_arb #(
  parameter int NUM_CHANNELS = dcra_pkg::NUM_CHANNELS_DEF
) (
  input  dcra_pkg::chan_stat_t stat [(NUM_CHANNELS > dcra_pkg::MAX_CHANNELS ?
                                      dcra_pkg::MAX_CHANNELS : NUM_CHANNELS)],
  input  logic [31:0]          dpcr,
  input  logic [6:0]           ask,
  output logic [2:0]           winner,
  output logic                 found
);
  import dcra_pkg::*;

  localparam int NCH = (NUM_CHANNELS > MAX_CHANNELS) ? MAX_CHANNELS : NUM_CHANNELS;

  logic [NCH-1:0] ready;
  logic [2:0]     best;

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      // channel six in manual sync mode also needs its trigger bit
      ready[i] = dpcr[4*i + 3] && stat[i].en &&
                 ((stat[i].sync != 2'b00) || (i != OTC_INDEX) || stat[i].trig);
    end
  end

  // Lowest priority field wins; later channels take ties
  always_comb begin
    winner = '0;
    found  = 1'b0;
    best   = '0;
    for (int i = 0; i < NCH; i++) begin
      if (ready[i] && ask[i] && (!found || (dpcr[4*i +: 3] <= best))) begin
        winner = 3'(i);
        best   = dpcr[4*i +: 3];
        found  = 1'b1;
      end
    end
  end

endmodule

[rtl/core/dma_channel_register_file_arbiter.sv]
// DMA channel register file and arbiter, top level.
// Path: input register, then result register, which holds the result until taken.
// Throughput: one item per cycle while results are taken; a stalled result lets one
// more item into the input register, then in_tready stays low until the result is
// taken.
// Reset (rst_n low, synchronous): channel regs zero, channel six control 2,
// priority 0x07654321, interrupt register zero, both pipeline stages empty.
// Depends on dcra_pkg, dcra_regs and dcra_arb.
module dma_channel_register_file_arbiter #(
  parameter int NUM_CHANNELS = dcra_pkg::NUM_CHANNELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [6:0] byte_offset, [38:7] write_value, [41:39] channel, [48:42] asking_mask
  input  logic [dcra_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [1:0] command
  input  logic [dcra_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] register read value, [32] irq_rise, [35:33] winner, [36] winner_found
  output logic [dcra_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import dcra_pkg::*;

  localparam int NCH = (NUM_CHANNELS > MAX_CHANNELS) ? MAX_CHANNELS : NUM_CHANNELS;

  // Input stage
  logic       s1_valid_r;
  req_t       s1_req_r;
  logic [6:0] s1_ask_r;

  // Result stage
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] out_data_nxt;

  logic       adv;
  logic [31:0] rdata;
  logic        rise;
  logic [31:0] dpcr;
  logic [2:0]  winner;
  logic        found;
  chan_stat_t  stat [NCH];

  // Advance the input stage whenever the result register is free or being drained;
  // register state is committed on that same edge, so the next item sees it.
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the item payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_req_r.cmd     <= cmd_t'(in_tuser[1:0]);
      s1_req_r.offset  <= in_tdata[6:0];
      s1_req_r.wdata   <= in_tdata[38:7];
      s1_req_r.channel <= in_tdata[41:39];
      s1_ask_r         <= in_tdata[48:42];
    end
  end

  dcra_regs #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv),
    .req   (s1_req_r),
    .rdata (rdata),
    .rise  (rise),
    .stat  (stat),
    .dpcr  (dpcr)
  );

  dcra_arb #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_arb (
    .stat   (stat),
    .dpcr   (dpcr),
    .ask    (s1_ask_r),
    .winner (winner),
    .found  (found)
  );

  // Keep only the fields that belong to this command; zero the rest
  always_comb begin
    out_data_nxt = '0;
    case (s1_req_r.cmd)
      CMD_READ:     out_data_nxt[31:0] = rdata;
      CMD_WRITE:    out_data_nxt[32]   = rise;
      CMD_COMPLETE: out_data_nxt[32]   = rise;
      CMD_ARB: begin
        out_data_nxt[35:33] = winner;
        out_data_nxt[36]    = found;
      end
      default: out_data_nxt = '0;
    endcase
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[test/testbench.sv]
// Self-checking testbench for the DMA channel register file and arbiter.
// Holds a bit-accurate register and arbitration predictor; needs dcra_pkg and the block.
`timescale 1ns / 1ps

module testbench;
  import dcra_pkg::*;

  localparam int CHANNELS = NUM_CHANNELS_DEF;

  // Register bits and masks the predictor works with
  localparam logic [31:0] ADDR_KEEP   = 32'h00FF_FFFF;
  localparam logic [31:0] CTRL_EN     = 32'h0100_0000;
  localparam logic [31:0] CTRL_TRIG   = 32'h1000_0000;
  localparam logic [31:0] IRQ_FORCE   = 32'h0000_8000;
  localparam logic [31:0] DICR_MASTER = 32'h0080_0000;
  localparam logic [6:0]  OFS_DPCR    = {DPCR_WORD, 2'b00};
  localparam logic [6:0]  OFS_DICR    = {DICR_WORD, 2'b00};

  // One bus access or event as it goes into the block
  typedef struct {
    cmd_t        cmd;
    logic [6:0]  offset;
    logic [31:0] wdata;
    logic [2:0]  channel;
    logic [6:0]  ask;
    bit          hold_until_drained;  // offer only once every result is back
  } bus_item_t;

  typedef struct packed {
    logic [31:0] rd_word;
    logic        irq_rise;
    logic [2:0]  winner;
    logic        winner_found;
  } bus_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Predictor state: a private copy of every register in the block
  logic [31:0] chan_addr  [CHANNELS];
  logic [31:0] chan_block [CHANNELS];
  logic [31:0] chan_ctrl  [CHANNELS];
  logic [31:0] prio_reg;
  logic [31:0] intr_reg;

  bus_item_t   pending_items[$];
  bus_result_t expected_results[$];
  bus_item_t   on_bus;
  int          items_accepted = 0;
  int          results_checked = 0;
  int          error_count = 0;
  int          gap_left = 0;
  int          burst_left = 0;
  int          stall_mode = 0;
  int          stall_phase = 0;
  int          rx_cycle = 0;
  int          long_hold_left = 0;
  bit          long_hold_done = 1'b0;

  dma_channel_register_file_arbiter #(
    .NUM_CHANNELS(CHANNELS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_registers();
    for (int i = 0; i < CHANNELS; i++) begin
      chan_addr[i]  = '0;
      chan_block[i] = '0;
      chan_ctrl[i]  = (i == OTC_INDEX) ? DIR_BIT : '0;
    end
    prio_reg = PRIO_RESET;
    intr_reg = '0;
  endfunction

  // Interrupt line: force, or master enable with any channel enabled and flagged
  function automatic bit irq_active();
    if (intr_reg[15]) return 1'b1;
    if (!intr_reg[23]) return 1'b0;
    return |(intr_reg[22:16] & intr_reg[30:24]);
  endfunction

  function automatic bit chan_ready(int ch);
    logic [31:0] c;
    c = chan_ctrl[ch];
    if (!prio_reg[ch * 4 + 3]) return 1'b0;
    if (!c[24]) return 1'b0;
    // Channel six in manual sync mode waits for its trigger bit
    if (c[10:9] == 2'd0 && ch == OTC_INDEX) return c[28];
    return 1'b1;
  endfunction

  function automatic logic [31:0] reg_peek(logic [6:0] ofs);
    logic [2:0] row;
    row = ofs[6:4];
    if (row != GLOBAL_ROW) begin
      if (row >= CHANNELS) return '0;
      case (ofs[3:2])
        SEL_ADDR:  return chan_addr[row];
        SEL_BLOCK: return chan_block[row];
        SEL_CTRL:  return chan_ctrl[row];
        default:   return '0;
      endcase
    end
    if (ofs[6:2] == DPCR_WORD) return prio_reg;
    if (ofs[6:2] == DICR_WORD) return {irq_active(), intr_reg[30:0]};
    return '0;
  endfunction

  // Returns 1 when the write raises the interrupt line
  function automatic bit reg_store(logic [6:0] ofs, logic [31:0] word);
    logic [2:0] row;
    logic [6:0] flags;
    bit         prior_irq;
    row = ofs[6:4];
    if (row != GLOBAL_ROW) begin
      if (row >= CHANNELS) return 1'b0;
      case (ofs[3:2])
        SEL_ADDR:  chan_addr[row] = word & ADDR_KEEP;
        SEL_BLOCK: chan_block[row] = word;
        SEL_CTRL:  chan_ctrl[row] = (row == OTC_INDEX) ? ((word & OTC_KEEP) | DIR_BIT) : word;
        default: ;
      endcase
      return 1'b0;
    end
    if (ofs[6:2] == DPCR_WORD) begin
      prio_reg = word;
      return 1'b0;
    end
    if (ofs[6:2] == DICR_WORD) begin
      prior_irq = irq_active();
      // Flags stay set unless acknowledged with a one
      flags = intr_reg[30:24] & ~word[30:24];
      intr_reg = (word & DICR_KEEP) | {1'b0, flags, 24'h0};
      return !prior_irq && irq_active();
    end
    return 1'b0;
  endfunction

  function automatic bit mark_complete(logic [2:0] ch);
    bit prior_irq;
    if (ch >= CHANNELS || ch > OTC_INDEX) return 1'b0;
    if (!intr_reg[16 + ch]) return 1'b0;
    prior_irq = irq_active();
    intr_reg[24 + ch] = 1'b1;
    return !prior_irq && irq_active();
  endfunction

  function automatic bus_result_t predict_item(bus_item_t item);
    bus_result_t r;
    logic [6:0]  word_ofs;
    logic [4:0]  lane_bits;
    logic [2:0]  prio;
    logic [2:0]  best;
    r = '0;
    best = '0;
    word_ofs = {item.offset[6:2], 2'b00};
    lane_bits = {item.offset[1:0], 3'b000};
    case (item.cmd)
      CMD_READ:     r.rd_word = reg_peek(word_ofs) >> lane_bits;
      CMD_WRITE:    r.irq_rise = reg_store(word_ofs, item.wdata << lane_bits);
      CMD_COMPLETE: r.irq_rise = mark_complete(item.channel);
      default: begin
        // Lowest priority field wins; a tie goes to the higher channel
        for (int i = 0; i < CHANNELS; i++) begin
          if (chan_ready(i) && item.ask[i]) begin
            prio = prio_reg[i * 4 +: 3];
            if (!r.winner_found || prio <= best) begin
              r.winner = 3'(i);
              r.winner_found = 1'b1;
              best = prio;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [6:0] chan_ofs(int ch, logic [1:0] sel);
    return {3'(ch), sel, 2'b00};
  endfunction

  task automatic add_item(cmd_t cmd, logic [6:0] ofs, logic [31:0] wdata = '0,
                          logic [2:0] ch = '0, logic [6:0] ask = '0, bit hold = 1'b0);
    bus_item_t item;
    item.cmd = cmd;
    item.offset = ofs;
    item.wdata = wdata;
    item.channel = ch;
    item.ask = ask;
    item.hold_until_drained = hold;
    pending_items.push_back(item);
  endtask

  // Mostly live registers at lane zero, sometimes any offset at all
  function automatic logic [6:0] pick_offset(int lane_odds);
    int         r;
    logic [6:0] ofs;
    r = $urandom_range(0, 9);
    if (r < 2) ofs = OFS_DPCR;
    else if (r < 4) ofs = OFS_DICR;
    else if (r < 9) ofs = chan_ofs($urandom_range(0, CHANNELS - 1), 2'($urandom_range(0, 2)));
    else ofs = 7'($urandom_range(0, 127));
    if ($urandom_range(0, lane_odds) == 0) ofs[1:0] = 2'($urandom_range(0, 3));
    return ofs;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    if (error_count <= 100)
      $display("%0t: %0s mismatch: got %0h, want %0h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer queued items in bursts, predict each one as it is taken
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
      gap_left = 0;
      burst_left = 0;
      reset_registers();
    end else begin
      // The item on the bus is taken at this edge: update the register copy
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_item(on_bus));
        items_accepted <= items_accepted + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() == 0 || gap_left > 0 ||
            (pending_items[0].hold_until_drained &&
             (in_tvalid || items_accepted != results_checked))) begin
          // Idle this cycle: inside a gap, out of items, or draining
          if (gap_left > 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          on_bus = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {7'h0, on_bus.ask, on_bus.channel, on_bus.wdata, on_bus.offset};
          in_tuser  <= on_bus.cmd;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // Start a new burst; about a quarter of them follow with no gap
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall on its own pattern, with one long hold-off mid-run
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (long_hold_left > 0) begin
        long_hold_left--;
        out_tready <= 1'b0;
      end else if (!long_hold_done && items_accepted >= 300) begin
        // Hold off long enough for the block to fill and push back on the input
        long_hold_done = 1'b1;
        long_hold_left = 80;
        out_tready <= 1'b0;
      end else begin
        if (stall_phase == 0) begin
          stall_mode = $urandom_range(0, 2);
          stall_phase = $urandom_range(8, 40);
        end
        stall_phase--;
        case (stall_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= (rx_cycle % 3) != 0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare every taken result with the oldest expectation
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    bus_result_t want;
    bus_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.rd_word      = out_tdata[31:0];
      got.irq_rise     = out_tdata[32];
      got.winner       = out_tdata[35:33];
      got.winner_found = out_tdata[36];
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", got.rd_word, '0);
      end else begin
        want = expected_results.pop_front();
        results_checked <= results_checked + 1;
        if (got.rd_word !== want.rd_word)
          report_mismatch("rd_word", got.rd_word, want.rd_word);
        if (got.irq_rise !== want.irq_rise)
          report_mismatch("irq_rise", 32'(got.irq_rise), 32'(want.irq_rise));
        if (got.winner !== want.winner)
          report_mismatch("winner", 32'(got.winner), 32'(want.winner));
        if (got.winner_found !== want.winner_found)
          report_mismatch("winner_found", 32'(got.winner_found), 32'(want.winner_found));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    // Reset values, lane reads and unused offsets
    add_item(CMD_READ, OFS_DPCR);
    add_item(CMD_READ, chan_ofs(OTC_INDEX, SEL_CTRL));
    add_item(CMD_READ, OFS_DPCR | 7'd1);
    add_item(CMD_READ, 7'h7F);
    // Enable every channel at equal priority, then arbitrate ties and no-ask
    add_item(CMD_WRITE, OFS_DPCR, 32'h0BBB_BBBB);
    add_item(CMD_WRITE, chan_ofs(2, SEL_CTRL), CTRL_EN);
    add_item(CMD_WRITE, chan_ofs(5, SEL_CTRL), CTRL_EN | 32'h0000_0200);
    add_item(CMD_ARB, '0, '0, '0, 7'h7F);
    add_item(CMD_ARB, '0, '0, '0, 7'h04);
    add_item(CMD_ARB, '0, '0, '0, 7'h00);
    // Channel six keeps only its writable bits; trigger decides readiness
    add_item(CMD_WRITE, chan_ofs(OTC_INDEX, SEL_CTRL), 32'hFFFF_FFFF);
    add_item(CMD_READ, chan_ofs(OTC_INDEX, SEL_CTRL));
    add_item(CMD_ARB, '0, '0, '0, 7'h40);
    add_item(CMD_WRITE, chan_ofs(OTC_INDEX, SEL_CTRL), CTRL_EN);
    add_item(CMD_ARB, '0, '0, '0, 7'h40);
    // Narrow writes replace the whole register; address keeps 24 bits
    add_item(CMD_WRITE, chan_ofs(0, SEL_ADDR) | 7'd1, 32'hFFFF_FFFF);
    add_item(CMD_READ, chan_ofs(0, SEL_ADDR));
    add_item(CMD_WRITE, chan_ofs(1, SEL_BLOCK) | 7'd2, 32'h1234_5678);
    add_item(CMD_READ, chan_ofs(1, SEL_BLOCK) | 7'd1);
    add_item(CMD_WRITE, 7'h0C, 32'hFFFF_FFFF);
    // Interrupts: enable, complete, ignored channel, acknowledge, force
    add_item(CMD_WRITE, OFS_DICR, DICR_MASTER | 32'h007F_0000);
    add_item(CMD_COMPLETE, '0, '0, 3'd3);
    add_item(CMD_COMPLETE, '0, '0, 3'd7);
    add_item(CMD_READ, OFS_DICR);
    add_item(CMD_WRITE, OFS_DICR, 32'h08FF_0000 | IRQ_FORCE);
    add_item(CMD_READ, OFS_DICR | 7'd3);

    // Random traffic; drain once partway through
    for (int n = 0; n < 650; n++) begin
      bus_item_t item;
      int        r;
      r = $urandom_range(0, 99);
      item.cmd = (r < 28) ? CMD_READ : (r < 60) ? CMD_WRITE : (r < 78) ? CMD_COMPLETE : CMD_ARB;
      item.offset = pick_offset((item.cmd == CMD_WRITE) ? 3 : 1);
      item.wdata = $urandom;
      item.channel = 3'($urandom_range(0, 7));
      item.ask = 7'($urandom_range(0, 127));
      item.hold_until_drained = (n == 200);
      pending_items.push_back(item);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_tvalid || items_accepted != results_checked)
      @(posedge clk);
    // Let the pipeline settle so any stray result is still caught
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("missing results", 32'(expected_results.size()), '0);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/dcra_pkg.sv
rtl/core/dcra_regs.sv
rtl/core/dcra_arb.sv
rtl/core/dma_channel_register_file_arbiter.sv
test/testbench.sv
